[design/jsu_pkg.sv]
// shared types, constants and utf-8 helpers for the json string unescaper
package jsu_pkg;

   // default depth of the queue between front and back
   localparam int JSU_QUEUE_DEPTH = 4;

   // ascii codes the parser looks for
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // decoded values of the single-character escapes
   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_CR = 8'h0D;
   localparam logic [7:0] CTL_HT = 8'h09;

   // replacement character for broken surrogates
   localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

   // parser modes
   typedef enum logic [2:0] {
      MODE_WAIT,
      MODE_BODY,
      MODE_ESC,
      MODE_HEX1,
      MODE_AFTER_HIGH,
      MODE_HIGH_BS,
      MODE_HEX2
   } mode_type;

   // result kinds
   typedef enum logic [1:0] {
      RK_BYTE,
      RK_DONE,
      RK_ERR
   } rkind_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_NO_QUOTE,
      ERR_CONTROL,
      ERR_ESCAPE,
      ERR_UNICODE,
      ERR_UNTERM
   } err_type;

   // back end emission phases
   typedef enum logic [1:0] {
      PH_REP,
      PH_CP,
      PH_TAIL
   } phase_type;

   // final single result of an item: byte, completion or error
   typedef struct packed {
      logic       en;
      rkind_type  kind;
      logic [7:0] data;
      err_type    err;
   } jsu_tail_type;

   // work for the back end: replacement, then a code point, then a tail beat
   typedef struct packed {
      logic         rep_en;
      logic         cp_en;
      logic [20:0]  cp;
      jsu_tail_type tail;
   } jsu_desc_type;

   // number of utf-8 bytes for a code point
   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] len;
      if (cp < 21'h80) begin
         len = 3'd1;
      end else if (cp < 21'h800) begin
         len = 3'd2;
      end else if (cp < 21'h10000) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

   // one byte of the utf-8 form of a code point
   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                            input logic [1:0] idx);
      logic [7:0] b;
      b = cp[7:0];
      case (len)
         3'd2: begin
            b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         end
         3'd3: begin
            case (idx)
               2'd0: b = {4'b1110, cp[15:12]};
               2'd1: b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd4: begin
            case (idx)
               2'd0: b = {5'b11110, cp[20:18]};
               2'd1: b = {2'b10, cp[17:12]};
               2'd2: b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: b = cp[7:0];
      endcase
      return b;
   endfunction

endpackage

[design/jsu_channels.sv]
// valid/ready channel interfaces for input beats and result beats

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] out_byte;
   logic [2:0] error_code;
   logic       last;

   modport source (output valid, output result_kind, output out_byte, output error_code,
                   output last, input ready);
   modport sink (input valid, input result_kind, input out_byte, input error_code,
                 input last, output ready);
endinterface

[design/jsu_front.sv]
// front end: parser state machine that turns each input beat that yields output into a work descriptor
module jsu_front (
   input  logic                 clock,
   input  logic                 reset,
   jsu_req_if.sink              req_chan,
   input  logic                 q_full,
   output logic                 q_push,
   output jsu_pkg::jsu_desc_type q_desc
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [11:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [9:0]  pend_ff, pend_in;

   logic         accept;
   logic [7:0]   b;
   logic         hex_ok;
   logic [3:0]   hval;
   logic [15:0]  unit;
   logic         unit_high, unit_low;
   logic [20:0]  pair_cp;
   jsu_desc_type desc;

   // sub-results of a body byte and of an escape character
   mode_type     body_mode, esc_mode;
   jsu_tail_type body_tail, esc_tail;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !q_full;
   assign b              = req_chan.data_byte;

   // hex digit decode
   always_comb begin
      hex_ok = 1'b1;
      hval   = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         hval = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         hval = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         hval = 4'(b - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // the complete code unit once the fourth digit arrives
   assign unit      = {acc_ff, hval};
   assign unit_high = (unit[15:10] == 6'b110110);
   assign unit_low  = (unit[15:10] == 6'b110111);
   assign pair_cp   = {({1'b0, pend_ff} + 11'd64), unit[9:0]};

   // plain byte inside the string
   always_comb begin
      body_mode = MODE_BODY;
      body_tail = '{en: 1'b1, kind: RK_BYTE, data: b, err: ERR_NONE};
      if (b == CH_QUOTE) begin
         body_mode = MODE_WAIT;
         body_tail = '{en: 1'b1, kind: RK_DONE, data: 8'd0, err: ERR_NONE};
      end else if (b == CH_BSLASH) begin
         body_mode = MODE_ESC;
         body_tail = '{en: 1'b0, kind: RK_BYTE, data: 8'd0, err: ERR_NONE};
      end else if (b < CH_SPACE) begin
         body_mode = MODE_WAIT;
         body_tail = '{en: 1'b1, kind: RK_ERR, data: 8'd0, err: ERR_CONTROL};
      end
   end

   // character after a backslash
   always_comb begin
      esc_mode = MODE_BODY;
      esc_tail = '{en: 1'b1, kind: RK_BYTE, data: b, err: ERR_NONE};
      case (b)
         CH_QUOTE, CH_BSLASH, CH_SLASH: esc_tail.data = b;
         CH_LOW_B: esc_tail.data = CTL_BS;
         CH_LOW_F: esc_tail.data = CTL_FF;
         CH_LOW_N: esc_tail.data = CTL_LF;
         CH_LOW_R: esc_tail.data = CTL_CR;
         CH_LOW_T: esc_tail.data = CTL_HT;
         CH_LOW_U: begin
            esc_mode    = MODE_HEX1;
            esc_tail.en = 1'b0;
         end
         default: begin
            esc_mode = MODE_WAIT;
            esc_tail = '{en: 1'b1, kind: RK_ERR, data: 8'd0, err: ERR_ESCAPE};
         end
      endcase
   end

   // next state and descriptor
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      pend_in = pend_ff;
      desc    = '{rep_en: 1'b0, cp_en: 1'b0, cp: 21'd0,
                  tail: '{en: 1'b0, kind: RK_BYTE, data: 8'd0, err: ERR_NONE}};
      if (req_chan.kind) begin
         // end of data
         mode_in       = MODE_WAIT;
         desc.tail.en  = 1'b1;
         desc.tail.kind = RK_ERR;
         case (mode_ff)
            MODE_WAIT: desc.tail.err = ERR_NO_QUOTE;
            MODE_HEX1, MODE_HEX2: desc.tail.err = ERR_UNICODE;
            MODE_AFTER_HIGH, MODE_HIGH_BS: begin
               desc.rep_en   = 1'b1;
               desc.tail.err = ERR_UNTERM;
            end
            default: desc.tail.err = ERR_UNTERM;
         endcase
      end else begin
         case (mode_ff)
            MODE_WAIT: begin
               if (b == CH_QUOTE) begin
                  mode_in = MODE_BODY;
               end else begin
                  desc.tail = '{en: 1'b1, kind: RK_ERR, data: 8'd0, err: ERR_NO_QUOTE};
               end
            end
            MODE_BODY: begin
               mode_in   = body_mode;
               desc.tail = body_tail;
            end
            MODE_ESC: begin
               mode_in   = esc_mode;
               desc.tail = esc_tail;
               acc_in    = 12'd0;
               cnt_in    = 2'd0;
            end
            MODE_HEX1, MODE_HEX2: begin
               if (!hex_ok) begin
                  mode_in   = MODE_WAIT;
                  desc.tail = '{en: 1'b1, kind: RK_ERR, data: 8'd0, err: ERR_UNICODE};
               end else if (cnt_ff == 2'd3) begin
                  if (mode_ff == MODE_HEX2 && unit_low) begin
                     // surrogate pair joins into one code point
                     mode_in    = MODE_BODY;
                     desc.cp_en = 1'b1;
                     desc.cp    = pair_cp;
                  end else begin
                     // unit on its own, after a replacement for an unpaired high unit
                     desc.rep_en = (mode_ff == MODE_HEX2);
                     desc.cp_en  = !unit_high;
                     desc.cp     = unit_low ? CP_REPLACEMENT : {5'd0, unit};
                     mode_in     = unit_high ? MODE_AFTER_HIGH : MODE_BODY;
                     pend_in     = unit[9:0];
                  end
               end else begin
                  acc_in = {acc_ff[7:0], hval};
                  cnt_in = cnt_ff + 2'd1;
               end
            end
            MODE_AFTER_HIGH: begin
               if (b == CH_BSLASH) begin
                  mode_in = MODE_HIGH_BS;
               end else begin
                  desc.rep_en = 1'b1;
                  mode_in     = body_mode;
                  desc.tail   = body_tail;
               end
            end
            MODE_HIGH_BS: begin
               acc_in = 12'd0;
               cnt_in = 2'd0;
               if (b == CH_LOW_U) begin
                  mode_in = MODE_HEX2;
               end else begin
                  desc.rep_en = 1'b1;
                  mode_in     = esc_mode;
                  desc.tail   = esc_tail;
               end
            end
            default: mode_in = MODE_WAIT;
         endcase
      end
   end

   assign q_push = accept && (desc.rep_en || desc.cp_en || desc.tail.en);
   assign q_desc = desc;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_WAIT;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

   // hex accumulator and pending high unit
   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

   // the second hex sequence is only entered after a backslash that follows a high unit
   a_hex2_entry: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HEX2 && $past(mode_ff) != MODE_HEX2) |-> $past(mode_ff) == MODE_HIGH_BS)
      else $error("second hex sequence entered from wrong mode");

endmodule

[design/jsu_fifo.sv]
// short descriptor queue between parser front end and result back end
module jsu_fifo #(
   parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  jsu_pkg::jsu_desc_type wr_data,
   output logic                 full,
   input  logic                 rd_en,
   output logic                 rd_valid,
   output jsu_pkg::jsu_desc_type rd_data
);
   import jsu_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   jsu_desc_type     store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = (count_ff == CNT_FULL);
   assign rd_valid = (count_ff != '0);
   assign rd_data  = store_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (rd_en && !wr_en) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && full && !rd_en) && !(rd_en && !rd_valid))
      else $error("queue overflow or underflow");

endmodule

[design/jsu_back.sv]
// back end: expands descriptors into utf-8, completion and error result beats
module jsu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  jsu_pkg::jsu_desc_type q_data,
   output logic                 q_pop,
   jsu_rsp_if.source            rsp_chan
);
   import jsu_pkg::*;

   jsu_desc_type cur_ff;
   logic         busy_ff;
   phase_type    phase_ff;
   logic [1:0]   idx_ff;

   logic       out_valid_ff;
   rkind_type  out_kind_ff;
   logic [7:0] out_byte_ff;
   err_type    out_err_ff;
   logic       out_last_ff;

   logic       advance, issue, load;
   logic [20:0] cp_sel;
   logic [2:0] len;
   rkind_type  beat_kind;
   logic [7:0] beat_byte;
   err_type    beat_err;
   logic       phase_end, more, beat_final;
   phase_type  phase_next, phase_start;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign issue   = busy_ff && advance;
   assign load    = q_valid && (!busy_ff || (issue && beat_final));
   assign q_pop   = load;

   // current beat from phase and byte index
   always_comb begin
      cp_sel    = (phase_ff == PH_REP) ? CP_REPLACEMENT : cur_ff.cp;
      len       = utf8_len(cp_sel);
      beat_kind = RK_BYTE;
      beat_byte = utf8_byte(cp_sel, len, idx_ff);
      beat_err  = ERR_NONE;
      phase_end = ({1'b0, idx_ff} == len - 3'd1);
      if (phase_ff == PH_TAIL) begin
         beat_kind = cur_ff.tail.kind;
         beat_byte = cur_ff.tail.data;
         beat_err  = cur_ff.tail.err;
         phase_end = 1'b1;
      end
   end

   // what follows the current phase
   always_comb begin
      more       = 1'b0;
      phase_next = PH_TAIL;
      case (phase_ff)
         PH_REP: begin
            if (cur_ff.cp_en) begin
               more       = 1'b1;
               phase_next = PH_CP;
            end else begin
               more = cur_ff.tail.en;
            end
         end
         PH_CP: more = cur_ff.tail.en;
         default: more = 1'b0;
      endcase
      beat_final = phase_end && !more;
   end

   // first phase of a new descriptor
   always_comb begin
      if (q_data.rep_en) begin
         phase_start = PH_REP;
      end else if (q_data.cp_en) begin
         phase_start = PH_CP;
      end else begin
         phase_start = PH_TAIL;
      end
   end

   // descriptor sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (issue && beat_final) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff   <= q_data;
         phase_ff <= phase_start;
         idx_ff   <= 2'd0;
      end else if (issue) begin
         if (phase_end) begin
            phase_ff <= phase_next;
            idx_ff   <= 2'd0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_kind_ff <= beat_kind;
         out_byte_ff <= beat_byte;
         out_err_ff  <= beat_err;
         out_last_ff <= beat_final;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_kind = out_kind_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.error_code  = out_err_ff;
   assign rsp_chan.last        = out_last_ff;

   // completion and error beats always close their item
   a_tail_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff != RK_BYTE) |-> out_last_ff)
      else $error("completion or error beat without last");

   // the tail phase is only reached for descriptors that carry a tail
   a_tail_phase: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && phase_ff == PH_TAIL) |-> cur_ff.tail.en)
      else $error("tail phase without tail");

endmodule

[design/json_string_unescape_utf8_top.sv]
// A result beat passes the queue entry, the back end descriptor and the output register.
// Throughput: one input beat per cycle while the queue is not full; results leave at one
// beat per cycle while the result side is ready; the descriptor queue absorbs the surplus.
// An input beat is refused only while the queue (DEPTH entries) is full.
// Reset is synchronous and active high: parser returns to waiting for a quote, queue and
// output register are emptied.
module json_string_unescape_utf8_top #(
   parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   jsu_req_if.sink    req_chan,
   jsu_rsp_if.source  rsp_chan
);
   import jsu_pkg::*;

   logic         q_push, q_full, q_pop, q_valid;
   jsu_desc_type q_wr_desc, q_rd_desc;

   // parser front end
   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_desc   (q_wr_desc)
   );

   // descriptor queue
   jsu_fifo #(
      .DEPTH (DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_wr_desc),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_rd_desc)
   );

   // result back end
   jsu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_rd_desc),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
